### rtl/mclw_pkg.sv
package mclw_pkg;

  localparam int DEF_CHANNELS  = 16;
  localparam int DEF_TIME_BITS = 48;

  localparam int CHAN_BITS    = 4;
  localparam int TIMEOUT_BITS = 16;
  localparam int FAULT_BITS   = 4;
  localparam int ACTION_BITS  = 3;
  localparam int MASK_BITS    = 16;

  // timeout * 1000 stays below 2^26
  localparam int LIMIT_BITS = 26;

  localparam logic [FAULT_BITS-1:0]  ACTION_MAX    = 4'd7;
  localparam logic [ACTION_BITS-1:0] ACTION_BUZZER = 3'd1;
  localparam int                     ROUND_UP      = 999;

  // floor(y / 1000) == (y * RECIP_MULT) >> RECIP_SHIFT for every y below 2^26
  localparam int                    RECIP_BITS  = 29;
  localparam logic [RECIP_BITS-1:0] RECIP_MULT  = 29'd274877907;
  localparam int                    RECIP_SHIFT = 38;
  localparam int                    PROD_BITS   = LIMIT_BITS + RECIP_BITS;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_FEED   = 2'd1,
    OP_CONFIG = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_t;

endpackage

### rtl/mclw_ram.sv
module mclw_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/multi_channel_liveness_watchdog.sv
// Liveness watchdog over CHANNELS software channels.
// Request channel (req_valid / req_stall) carries one command per transaction:
// tick scan, feed, configure or query, with the current microsecond time.
// Response channel (rsp_valid / rsp_stall) returns exactly one result per
// command from an output register; a new command is taken while a result
// still waits there.
// Feed, configure and query pass through the read, execute and done states,
// and the next command is taken only after the result is loaded.
// A tick walks every channel through one shared subtract / compare /
// reciprocal-multiply unit: a disabled channel passes the read and subtract
// states only, one that timed out also compare and write-back, and a live
// one compare, multiply and write-back; the done state then loads the
// result. Each channel takes one table read.
// req_stall is high during reset and from acceptance until the result is
// loaded into the output register; if that register is still held by
// rsp_stall, the block waits with the finished result and keeps req_stall high.
// Reset clears all channels to disabled at once through per-entry valid bits;
// a command can be taken as soon as reset is low.
module multi_channel_liveness_watchdog import mclw_pkg::*; #(
  parameter int CHANNELS  = DEF_CHANNELS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic [1:0]              opcode,
  input  logic [CHAN_BITS-1:0]    channel,
  input  logic [TIME_BITS-1:0]    time_us,
  input  logic [TIMEOUT_BITS-1:0] timeout_ms,
  input  logic [FAULT_BITS-1:0]   action_code,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output logic                    status,
  output logic                    online,
  output logic [TIMEOUT_BITS-1:0] remaining_ms,
  output logic [MASK_BITS-1:0]    offline_mask,
  output logic                    all_online,
  output logic                    buzzer_on
);

  localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FEED_LSB   = TIMEOUT_BITS;
  localparam int ACT_LSB    = FEED_LSB + TIME_BITS;
  localparam int TMO_LSB    = ACT_LSB + ACTION_BITS;
  localparam int ENTRY_BITS = TMO_LSB + TIMEOUT_BITS;
  localparam logic [CH_BITS-1:0] LAST_CH = CH_BITS'(CHANNELS - 1);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_READ    = 9'b000000010,
    ST_EXEC    = 9'b000000100,
    ST_SC_READ = 9'b000001000,
    ST_SC_SUB  = 9'b000010000,
    ST_SC_CMP  = 9'b000100000,
    ST_SC_MUL  = 9'b001000000,
    ST_SC_WR   = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_t;

  state_t state;

  // latched command
  opcode_t                  op_q;
  logic [CHAN_BITS-1:0]     ch_q;
  logic [TIME_BITS-1:0]     now_q;
  logic [TIMEOUT_BITS-1:0]  tmo_q;
  logic [FAULT_BITS-1:0]    act_q;

  // scan datapath
  logic [CH_BITS-1:0]       idx;
  logic [TIMEOUT_BITS-1:0]  ent_tmo;
  logic [ACTION_BITS-1:0]   ent_act;
  logic [TIME_BITS-1:0]     ent_feed;
  logic [TIME_BITS-1:0]     elapsed;
  logic [LIMIT_BITS-1:0]    limit;
  logic [LIMIT_BITS-1:0]    y;
  logic [PROD_BITS-1:0]     prod;
  logic                     timed_out;
  logic [31:0]              idx32;

  // pending result
  logic                     res_status;
  logic                     res_online;
  logic [TIMEOUT_BITS-1:0]  res_rem;
  logic [MASK_BITS-1:0]     res_mask;
  logic                     res_all;
  logic                     res_buzz;

  // channel table
  logic [CHANNELS-1:0]      vld;
  logic                     rd_ok;
  logic                     ram_we;
  logic                     ram_re;
  logic [CH_BITS-1:0]       ram_waddr;
  logic [CH_BITS-1:0]       ram_raddr;
  logic [ENTRY_BITS-1:0]    ram_wdata;
  logic [ENTRY_BITS-1:0]    ram_rdata;
  logic [ENTRY_BITS-1:0]    rd_ent;
  logic [TIMEOUT_BITS-1:0]  rd_tmo;
  logic [ACTION_BITS-1:0]   rd_act;
  logic [TIME_BITS-1:0]     rd_feed;
  logic [TIMEOUT_BITS-1:0]  rd_rem;
  logic [LIMIT_BITS-1:0]    rd_tmo_w;

  logic                     ch_ok;
  logic [CH_BITS-1:0]       ch_addr;
  logic                     last_ch;
  logic                     out_free;
  logic [TIMEOUT_BITS-1:0]  rem_new;

  assign req_stall = rst || (state != ST_IDLE);
  assign ch_ok     = (32'(ch_q) < CHANNELS);
  assign ch_addr   = CH_BITS'(32'(ch_q));
  assign last_ch   = (idx == LAST_CH);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign idx32     = 32'(idx);

  // an entry never written reads as a disabled channel
  assign rd_ent   = rd_ok ? ram_rdata : '0;
  assign rd_tmo   = rd_ent[TMO_LSB +: TIMEOUT_BITS];
  assign rd_act   = rd_ent[ACT_LSB +: ACTION_BITS];
  assign rd_feed  = rd_ent[FEED_LSB +: TIME_BITS];
  assign rd_rem   = rd_ent[0 +: TIMEOUT_BITS];
  assign rd_tmo_w = LIMIT_BITS'(rd_tmo);

  assign rem_new = timed_out ? '0 : prod[RECIP_SHIFT +: TIMEOUT_BITS];

  assign ram_re    = (state inside {ST_READ, ST_SC_READ});
  assign ram_raddr = (state == ST_SC_READ) ? idx : ch_addr;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ch_addr;
    ram_wdata = '0;
    case (state)
      ST_EXEC: begin
        if (op_q == OP_FEED && ch_ok) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_tmo, rd_act, now_q, rd_tmo};
        end else if (op_q == OP_CONFIG && act_q <= ACTION_MAX && ch_ok) begin
          ram_we    = 1'b1;
          ram_wdata = {tmo_q, act_q[ACTION_BITS-1:0], now_q, tmo_q};
        end
      end
      ST_SC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = {ent_tmo, ent_act, ent_feed, rem_new};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  mclw_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CHANNELS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      vld       <= '0;
    end else begin
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= (opcode_t'(opcode) == OP_TICK) ? ST_SC_READ : ST_READ;
          end
        end
        ST_READ:    state <= ST_EXEC;
        ST_EXEC:    state <= ST_DONE;
        ST_SC_READ: state <= ST_SC_SUB;
        ST_SC_SUB: begin
          if (rd_tmo != '0) begin
            state <= ST_SC_CMP;
          end else begin
            state <= last_ch ? ST_DONE : ST_SC_READ;
          end
        end
        ST_SC_CMP: state <= (elapsed < TIME_BITS'(limit)) ? ST_SC_MUL : ST_SC_WR;
        ST_SC_MUL: state <= ST_SC_WR;
        ST_SC_WR:  state <= last_ch ? ST_DONE : ST_SC_READ;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_ok <= vld[ram_raddr];
    end
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op_q       <= opcode_t'(opcode);
          ch_q       <= channel;
          now_q      <= time_us;
          tmo_q      <= timeout_ms;
          act_q      <= action_code;
          idx        <= '0;
          res_status <= 1'b0;
          res_online <= 1'b0;
          res_rem    <= '0;
          res_mask   <= '0;
          res_all    <= (opcode_t'(opcode) == OP_TICK);
          res_buzz   <= 1'b0;
        end
      end
      ST_EXEC: begin
        if (op_q == OP_CONFIG && act_q > ACTION_MAX) begin
          res_status <= 1'b1;
        end
        if (op_q == OP_QUERY) begin
          res_online <= !ch_ok || (rd_tmo == '0) || (rd_rem != '0);
          res_rem    <= ch_ok ? rd_rem : '0;
        end
      end
      ST_SC_SUB: begin
        ent_tmo  <= rd_tmo;
        ent_act  <= rd_act;
        ent_feed <= rd_feed;
        elapsed  <= now_q - rd_feed;
        // timeout * 1000 as 1024 - 16 - 8
        limit    <= (rd_tmo_w << 10) - (rd_tmo_w << 4) - (rd_tmo_w << 3);
        if (rd_tmo == '0 && !last_ch) begin
          idx <= idx + 1'b1;
        end
      end
      ST_SC_CMP: begin
        if (elapsed < TIME_BITS'(limit)) begin
          timed_out <= 1'b0;
          y <= limit - elapsed[LIMIT_BITS-1:0] + LIMIT_BITS'(ROUND_UP);
        end else begin
          timed_out <= 1'b1;
          res_all   <= 1'b0;
          if (idx32 < 32'(MASK_BITS)) begin
            res_mask[idx32[3:0]] <= 1'b1;
          end
          if (ent_act == ACTION_BUZZER) begin
            res_buzz <= 1'b1;
          end
        end
      end
      ST_SC_MUL: begin
        prod <= y * RECIP_MULT;
      end
      ST_SC_WR: begin
        if (!last_ch) begin
          idx <= idx + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          status       <= res_status;
          online       <= res_online;
          remaining_ms <= res_rem;
          offline_mask <= res_mask;
          all_online   <= res_all;
          buzzer_on    <= res_buzz;
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("command accepted while previous one still in progress");

  a_mask_vs_all: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(all_online && offline_mask != '0))
    else $error("all_online reported with channels offline");

  a_buzz_offline: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && buzzer_on) |-> !all_online)
    else $error("buzzer on without an offline channel");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status) |-> (!online && remaining_ms == '0 && !all_online))
    else $error("rejected configure carries other result fields");

  a_scan_enabled: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SC_WR) |-> (ent_tmo != '0))
    else $error("scan rewrites a disabled channel");

endmodule

### tb/sv/mclw_monitor.sv
`timescale 1ns / 1ps

module mclw_monitor import mclw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  input  logic                     req_stall,
  input  logic [1:0]               opcode,
  input  logic [CHAN_BITS-1:0]     channel,
  input  logic [DEF_TIME_BITS-1:0] time_us,
  input  logic [TIMEOUT_BITS-1:0]  timeout_ms,
  input  logic [FAULT_BITS-1:0]    action_code,
  input  logic                     rsp_valid,
  input  logic                     rsp_stall,
  input  logic                     status,
  input  logic                     online,
  input  logic [TIMEOUT_BITS-1:0]  remaining_ms,
  input  logic [MASK_BITS-1:0]     offline_mask,
  input  logic                     all_online,
  input  logic                     buzzer_on,
  output int                       mismatches,
  output int                       outstanding
);

  localparam int NCH          = DEF_CHANNELS;
  localparam int TBITS        = DEF_TIME_BITS;
  localparam int US_PER_MS    = 1000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                    status;
    logic                    online;
    logic [TIMEOUT_BITS-1:0] remaining;
    logic [MASK_BITS-1:0]    mask;
    logic                    all_on;
    logic                    buzz;
  } answer_t;

  logic [TIMEOUT_BITS-1:0] timeout_tbl [NCH];
  logic [ACTION_BITS-1:0]  action_tbl  [NCH];
  logic [TBITS-1:0]        feed_tbl    [NCH];
  logic [TIMEOUT_BITS-1:0] remain_tbl  [NCH];

  answer_t expected_answers [$];

  // Apply one command to the channel tables and return the answer it produces.
  function automatic answer_t compute_answer(opcode_t op, logic [CHAN_BITS-1:0] ch,
                                             logic [TBITS-1:0] now,
                                             logic [TIMEOUT_BITS-1:0] tmo,
                                             logic [FAULT_BITS-1:0] act);
    answer_t          ans;
    logic [TBITS-1:0] elapsed;
    logic [TBITS-1:0] limit;
    int               i;
    ans = '0;
    case (op)
      OP_TICK: begin
        ans.all_on = 1'b1;
        for (i = 0; i < NCH; i++) begin
          if (timeout_tbl[i] != '0) begin
            elapsed = now - feed_tbl[i];
            limit   = TBITS'(timeout_tbl[i]) * TBITS'(US_PER_MS);
            if (elapsed < limit) begin
              // round the leftover time up to whole milliseconds
              remain_tbl[i] = TIMEOUT_BITS'((limit - elapsed + TBITS'(ROUND_UP))
                                            / TBITS'(US_PER_MS));
            end else begin
              remain_tbl[i] = '0;
              ans.all_on = 1'b0;
              if (i < MASK_BITS) ans.mask[i] = 1'b1;
              if (action_tbl[i] == ACTION_BUZZER) ans.buzz = 1'b1;
            end
          end
        end
      end
      OP_FEED: begin
        remain_tbl[ch] = timeout_tbl[ch];
        feed_tbl[ch]   = now;
      end
      OP_CONFIG: begin
        if (act > ACTION_MAX) begin
          ans.status = 1'b1;
        end else begin
          timeout_tbl[ch] = tmo;
          action_tbl[ch]  = act[ACTION_BITS-1:0];
          remain_tbl[ch]  = tmo;
          feed_tbl[ch]    = now;
        end
      end
      default: begin
        ans.online    = (timeout_tbl[ch] == '0) || (remain_tbl[ch] != '0);
        ans.remaining = remain_tbl[ch];
      end
    endcase
    return ans;
  endfunction

  task automatic check_field(string field, logic [MASK_BITS-1:0] want,
                             logic [MASK_BITS-1:0] got);
    if (want !== got) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        timeout_tbl[i] = '0;
        action_tbl[i]  = '0;
        feed_tbl[i]    = '0;
        remain_tbl[i]  = '0;
      end
      expected_answers.delete();
      mismatches = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_answers.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result transaction with nothing expected", $time);
          mismatches = mismatches + 1;
        end else begin
          want = expected_answers.pop_front();
          check_field("status",       want.status,    status);
          check_field("online",       want.online,    online);
          check_field("remaining_ms", want.remaining, remaining_ms);
          check_field("offline_mask", want.mask,      offline_mask);
          check_field("all_online",   want.all_on,    all_online);
          check_field("buzzer_on",    want.buzz,      buzzer_on);
        end
      end
      if (req_valid && !req_stall)
        expected_answers.push_back(compute_answer(opcode_t'(opcode), channel, time_us,
                                                  timeout_ms, action_code));
    end
    outstanding = expected_answers.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import mclw_pkg::*;

  localparam int ITEMS_PER_PHASE = 400;
  localparam int QUIET_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 100;
  localparam logic [DEF_TIME_BITS-1:0] NEAR_WRAP = 48'hFFFF_FFFF_FE0C;
  localparam logic [DEF_TIME_BITS-1:0] ALL_ONES  = 48'hFFFF_FFFF_FFFF;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     req_valid    = 1'b0;
  logic                     req_stall;
  logic [1:0]               opcode       = '0;
  logic [CHAN_BITS-1:0]     channel      = '0;
  logic [DEF_TIME_BITS-1:0] time_us      = '0;
  logic [TIMEOUT_BITS-1:0]  timeout_ms   = '0;
  logic [FAULT_BITS-1:0]    action_code  = '0;
  logic                     rsp_valid;
  logic                     rsp_stall    = 1'b0;
  logic                     status;
  logic                     online;
  logic [TIMEOUT_BITS-1:0]  remaining_ms;
  logic [MASK_BITS-1:0]     offline_mask;
  logic                     all_online;
  logic                     buzzer_on;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;

  logic [DEF_TIME_BITS-1:0] now_us = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_channel_liveness_watchdog i_dut (.*);

  mclw_monitor i_monitor (.*);

  always @(negedge clk) rsp_stall <= ($urandom_range(0, 99) < stall_pct);

  // end the run when no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_command(opcode_t op, logic [CHAN_BITS-1:0] ch,
                              logic [DEF_TIME_BITS-1:0] t,
                              logic [TIMEOUT_BITS-1:0] tmo, logic [FAULT_BITS-1:0] act);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid    <= 1'b1;
    opcode       <= op;
    channel      <= ch;
    time_us      <= t;
    timeout_ms   <= tmo;
    action_code  <= act;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic send_random_command();
    int                      roll;
    opcode_t                 op;
    logic [TIMEOUT_BITS-1:0] tmo;
    logic [FAULT_BITS-1:0]   act;
    roll = $urandom_range(0, 99);
    // mostly advance time a little, now and then jump anywhere
    if (roll < 2) now_us = DEF_TIME_BITS'({$urandom, $urandom});
    else now_us = now_us + DEF_TIME_BITS'($urandom_range(0, 700));
    roll = $urandom_range(0, 99);
    if (roll < 30) op = OP_TICK;
    else if (roll < 62) op = OP_FEED;
    else if (roll < 75) op = OP_CONFIG;
    else op = OP_QUERY;
    tmo = TIMEOUT_BITS'($urandom);
    act = FAULT_BITS'($urandom);
    if (op == OP_CONFIG) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) tmo = '0;
      else if (roll < 15) tmo = '1;
      else if (roll >= 22) tmo = TIMEOUT_BITS'($urandom_range(1, 20));
      roll = $urandom_range(0, 99);
      if (roll < 15) act = FAULT_BITS'($urandom_range(8, 15));
      else if (roll < 50) act = FAULT_BITS'(ACTION_BUZZER);
      else act = FAULT_BITS'($urandom_range(0, 7));
    end
    send_command(op, CHAN_BITS'($urandom_range(0, 15)), now_us, tmo, act);
  endtask

  initial begin
    int phase;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // disabled channels after reset
    send_command(OP_QUERY,  4'd0,  '0, '0, '0);
    send_command(OP_TICK,   4'd0,  '0, '0, '0);
    send_command(OP_CONFIG, 4'd0,  NEAR_WRAP, 16'd1, FAULT_BITS'(ACTION_BUZZER));
    send_command(OP_CONFIG, 4'd15, NEAR_WRAP, 16'hFFFF, ACTION_MAX);
    // invalid actions leave the channel untouched
    send_command(OP_CONFIG, 4'd3,  NEAR_WRAP, 16'd5, 4'd8);
    send_command(OP_CONFIG, 4'd3,  NEAR_WRAP, 16'd5, 4'd15);
    send_command(OP_QUERY,  4'd3,  NEAR_WRAP, '0, '0);
    send_command(OP_QUERY,  4'd15, NEAR_WRAP, '0, '0);
    // elapsed time across the wrap of the microsecond counter
    send_command(OP_TICK,   4'd0,  NEAR_WRAP + 48'd400, '0, '0);
    send_command(OP_TICK,   4'd0,  48'd300, '0, '0);
    send_command(OP_TICK,   4'd0,  48'd500, '0, '0);
    send_command(OP_QUERY,  4'd0,  48'd500, '0, '0);
    send_command(OP_FEED,   4'd0,  48'd600, '0, '0);
    send_command(OP_QUERY,  4'd0,  48'd600, '0, '0);
    // feed of a disabled channel
    send_command(OP_FEED,   4'd5,  48'd600, '0, '0);
    send_command(OP_QUERY,  4'd5,  48'd600, '0, '0);
    send_command(OP_CONFIG, 4'd15, 48'd700, 16'd0, 4'd0);
    send_command(OP_CONFIG, 4'd2,  48'd0, 16'hFFFF, FAULT_BITS'(ACTION_BUZZER));
    // largest timeout, one microsecond short and exactly on the limit
    send_command(OP_TICK,   4'd0,  48'd65534999, '0, '0);
    send_command(OP_TICK,   4'd0,  48'd65535000, '0, '0);
    send_command(OP_TICK,   4'd0,  ALL_ONES, '0, '0);
    send_command(OP_QUERY,  4'd2,  ALL_ONES, '0, '0);

    now_us = ALL_ONES - 48'd20000;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      repeat (ITEMS_PER_PHASE) send_random_command();
    end

    req_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
